FILE: design/edid_pkg.sv
// ----------------------------------------------------------------------------
// EDID parser package
// Shared record and job types, codes and decode tables for the EDID parser.
// ----------------------------------------------------------------------------
package edid_pkg;

  // Record kinds.
  localparam logic [3:0] KIND_VENDOR   = 4'd0;
  localparam logic [3:0] KIND_SERIAL   = 4'd1;
  localparam logic [3:0] KIND_DATE     = 4'd2;
  localparam logic [3:0] KIND_VERSION  = 4'd3;
  localparam logic [3:0] KIND_INPUT    = 4'd4;
  localparam logic [3:0] KIND_SIZE     = 4'd5;
  localparam logic [3:0] KIND_GAMMA    = 4'd6;
  localparam logic [3:0] KIND_FEATURES = 4'd7;
  localparam logic [3:0] KIND_CHROMA   = 4'd8;
  localparam logic [3:0] KIND_EST      = 4'd9;
  localparam logic [3:0] KIND_STD      = 4'd10;
  localparam logic [3:0] KIND_DETAILED = 4'd11;
  localparam logic [3:0] KIND_TEXT     = 4'd12;
  localparam logic [3:0] KIND_STATUS   = 4'd13;

  localparam int unsigned HoldDepth = 18;
  localparam int unsigned DtdParts  = 7;

  // Job operations passed from the front to the back.
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_SINGLE = 2'd1,
    OP_EST    = 2'd2,
    OP_DTD    = 2'd3
  } op_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [4:0]  slot;
    logic [2:0]  part;
    logic [31:0] val_a;
    logic [15:0] val_b;
    logic [15:0] val_c;
    logic        present;
  } rec_t;

  typedef struct packed {
    op_e               op;
    rec_t              rec;
    logic [7:0]        est_mask;
    logic [1:0]        est_grp;
    logic [4:0]        est_base;
    logic [17:0][7:0]  dtd;
    logic [2:0]        dtd_slot;
  } job_t;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] hz;
  } est_t;

  function automatic est_t est_entry(input logic [4:0] idx);
    est_t e;
    case (idx)
      5'd0:  e = '{16'd800,  16'd600,  16'd60};
      5'd1:  e = '{16'd800,  16'd600,  16'd56};
      5'd2:  e = '{16'd640,  16'd480,  16'd75};
      5'd3:  e = '{16'd640,  16'd480,  16'd72};
      5'd4:  e = '{16'd640,  16'd480,  16'd67};
      5'd5:  e = '{16'd640,  16'd480,  16'd60};
      5'd6:  e = '{16'd720,  16'd400,  16'd88};
      5'd7:  e = '{16'd720,  16'd400,  16'd70};
      5'd8:  e = '{16'd1280, 16'd1024, 16'd75};
      5'd9:  e = '{16'd1024, 16'd768,  16'd75};
      5'd10: e = '{16'd1024, 16'd768,  16'd70};
      5'd11: e = '{16'd1024, 16'd768,  16'd60};
      5'd12: e = '{16'd1024, 16'd768,  16'd87};
      5'd13: e = '{16'd832,  16'd624,  16'd75};
      5'd14: e = '{16'd800,  16'd600,  16'd75};
      5'd15: e = '{16'd800,  16'd600,  16'd72};
      5'd23: e = '{16'd1152, 16'd870,  16'd75};
      default: e = '0;
    endcase
    return e;
  endfunction

  // Bits of each established byte that name a real mode.
  function automatic logic [7:0] est_valid(input logic [1:0] grp);
    logic [7:0] m;
    case (grp)
      2'd0, 2'd1: m = 8'hFF;
      2'd2:       m = 8'h80;
      default:    m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [4:0] depth_bits(input logic [2:0] code);
    logic [4:0] d;
    case (code)
      3'd1: d = 5'd6;
      3'd2: d = 5'd8;
      3'd3: d = 5'd10;
      3'd4: d = 5'd12;
      3'd5: d = 5'd14;
      3'd6: d = 5'd16;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

  // Portrait aspect ratio in hundredths, rounded, indexed by the height byte.
  // Each entry is a seven-bit restoring division done while elaborating.
  typedef logic [6:0] asp_lut_t [256];

  function automatic asp_lut_t build_asp();
    asp_lut_t    res;
    int unsigned d, r, q;
    for (int i = 0; i < 256; i++) begin
      d = i + 99;
      r = 10000 + (d >> 1);
      q = 0;
      for (int b = 6; b >= 0; b--) begin
        if (r >= (d << b)) begin
          r = r - (d << b);
          q = q | (1 << b);
        end
      end
      res[i] = 7'(q);
    end
    return res;
  endfunction

  localparam asp_lut_t ASP_LUT = build_asp();

endpackage

FILE: design/edid_front.sv
// ----------------------------------------------------------------------------
// EDID parser front end
// Accepts bytes, keeps the block state and turns each byte into at most one job.
// ----------------------------------------------------------------------------
module edid_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         byte_value_i,
  input  logic               restart_i,
  input  logic               full_i,
  output logic               push_o,
  output edid_pkg::job_t     job_o
);
  import edid_pkg::*;

  logic [6:0] pos_q, pos_d, pos_c;
  logic [4:0] hidx_q, hidx_d, hidx_c, hidx_prev;
  logic [7:0] sum_q, sum_d, sum_c, sum_n;
  logic       hm_q, hm_d, hm_c, hm_n;
  logic [2:0] dcnt_q, dcnt_d, dcnt_c;
  logic [4:0] ecnt_q, ecnt_d, ecnt_c;
  logic [1:0] tm_q, tm_d, tm_c;
  logic [7:0] held_q [HoldDepth];
  logic       accept;
  logic [7:0] v;
  job_t       job;
  logic       is_desc;
  logic [7:0] want, lo, f, emask;
  logic [2:0] k, std_i;
  logic [1:0] dnum;
  logic [3:0] ecount;
  logic [15:0] sw, sht;
  logic [27:0] sw5;

  assign v          = byte_value_i;
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    pos_c  = restart_i ? 7'd0 : pos_q;
    hidx_c = restart_i ? 5'd0 : hidx_q;
    sum_c  = restart_i ? 8'd0 : sum_q;
    hm_c   = restart_i ? 1'b1 : hm_q;
    dcnt_c = restart_i ? 3'd0 : dcnt_q;
    ecnt_c = restart_i ? 5'd0 : ecnt_q;
    tm_c   = restart_i ? 2'd0 : tm_q;
  end

  always_comb begin
    sum_n = sum_c + v;
    want  = (pos_c == 7'd0 || pos_c == 7'd7) ? 8'h00 : 8'hFF;
    hm_n  = hm_c && !(pos_c < 7'd8 && v != want);
    hidx_prev = (hidx_c == 5'd0) ? 5'(HoldDepth - 1) : hidx_c - 5'd1;
    is_desc = (held_q[0] == 8'd0) && (held_q[1] == 8'd0);
    k     = 3'(pos_c - 7'h1B);
    lo    = k[2] ? held_q[8] : held_q[7];
    std_i = 3'((pos_c - 7'h27) >> 1);
    f     = held_q[hidx_prev];
    sw    = 16'(8 * (16'(f) + 16'd31));
    sw5   = 28'((28'(sw) * 28'd3277) >> 14);
    case (v[7:6])
      2'd0:    sht = 16'((sw >> 4) * 16'd10);
      2'd1:    sht = 16'((sw >> 2) * 16'd3);
      2'd2:    sht = 16'(sw5[15:0] * 16'd4);
      default: sht = 16'((sw >> 4) * 16'd9);
    endcase
    emask  = v & est_valid(2'(pos_c - 7'h23));
    ecount = 4'($countones(emask));
    if (pos_c < 7'd72)       dnum = 2'd0;
    else if (pos_c < 7'd90)  dnum = 2'd1;
    else if (pos_c < 7'd108) dnum = 2'd2;
    else                     dnum = 2'd3;

    job          = '0;
    job.op       = OP_NONE;
    job.est_mask = emask;
    job.est_grp  = 2'(pos_c - 7'h23);
    job.est_base = ecnt_c;
    job.dtd_slot = dcnt_c;
    for (int i = 0; i < HoldDepth; i++) job.dtd[i] = held_q[i];
    job.dtd[HoldDepth - 1] = v;
    job.rec.present = 1'b1;

    tm_d   = tm_c;
    dcnt_d = dcnt_c;
    ecnt_d = ecnt_c;

    if (hm_n) begin
      if (pos_c == 7'h0B) begin
        job.op = OP_SINGLE;
        job.rec.kind  = KIND_VENDOR;
        job.rec.val_a = {8'd0, 3'b010, held_q[8][6:2], 3'b010,
                         held_q[8][1:0], held_q[9][7:5], 3'b010, held_q[9][4:0]};
        job.rec.val_b = {v, held_q[10]};
      end else if (pos_c == 7'h0F) begin
        job.op = OP_SINGLE;
        job.rec.kind  = KIND_SERIAL;
        job.rec.val_a = {v, held_q[14], held_q[13], held_q[12]};
      end else if (pos_c == 7'h11) begin
        job.op = OP_SINGLE;
        job.rec.kind = KIND_DATE;
        if (held_q[16] != 8'd0 && held_q[16] != 8'hFF) begin
          job.rec.val_a = 32'(held_q[16]);
          job.rec.val_c = 16'd2;
        end else if (held_q[16] == 8'hFF) begin
          job.rec.val_c = 16'd1;
        end
        job.rec.val_b = 16'd1990 + 16'(v);
      end else if (pos_c == 7'h13) begin
        job.op = OP_SINGLE;
        job.rec.kind  = KIND_VERSION;
        job.rec.val_a = 32'(held_q[0]);
        job.rec.val_b = 16'(v);
      end else if (pos_c == 7'h14) begin
        job.op = OP_SINGLE;
        job.rec.kind = KIND_INPUT;
        if (v[7]) begin
          job.rec.val_a = 32'd1;
          job.rec.val_b = 16'(depth_bits(v[6:4]));
          job.rec.val_c = 16'(v[3:0]);
        end else begin
          job.rec.val_b = 16'(v[6:5]);
          job.rec.val_c = 16'(v[4:0]);
        end
      end else if (pos_c == 7'h16) begin
        job.op = OP_SINGLE;
        job.rec.kind = KIND_SIZE;
        if (held_q[3] == 8'd0 && v == 8'd0) begin
          job.rec.present = 1'b0;
        end else if (v == 8'd0) begin
          job.rec.val_c = 16'(held_q[3]) + 16'd99;
        end else if (held_q[3] == 8'd0) begin
          job.rec.val_c = 16'(ASP_LUT[v]);
        end else begin
          job.rec.val_a = 32'(16'(held_q[3]) * 16'd10);
          job.rec.val_b = 16'(v) * 16'd10;
        end
      end else if (pos_c == 7'h17) begin
        job.op = OP_SINGLE;
        job.rec.kind = KIND_GAMMA;
        if (v == 8'hFF) job.rec.present = 1'b0;
        else job.rec.val_a = 32'(v) + 32'd100;
      end else if (pos_c == 7'h18) begin
        job.op = OP_SINGLE;
        job.rec.kind  = KIND_FEATURES;
        job.rec.val_a = 32'(v[7:5]);
        job.rec.val_b = 16'(v[4:3]);
        job.rec.val_c = 16'(v[2:0]);
      end else if (pos_c >= 7'h1B && pos_c <= 7'h22) begin
        job.op = OP_SINGLE;
        job.rec.kind = KIND_CHROMA;
        job.rec.slot = 5'(k);
        case (k[1:0])
          2'd0:    job.rec.val_a = {22'd0, v, lo[7:6]};
          2'd1:    job.rec.val_a = {22'd0, v, lo[5:4]};
          2'd2:    job.rec.val_a = {22'd0, v, lo[3:2]};
          default: job.rec.val_a = {22'd0, v, lo[1:0]};
        endcase
      end else if (pos_c >= 7'h23 && pos_c <= 7'h25) begin
        if (ecount != 4'd0) job.op = OP_EST;
        ecnt_d = ecnt_c + 5'(ecount);
      end else if (pos_c >= 7'h27 && pos_c <= 7'h35 && pos_c[0]) begin
        job.op = OP_SINGLE;
        job.rec.kind = KIND_STD;
        job.rec.slot = 5'(std_i);
        if (f == 8'h01 || v == 8'h01) begin
          job.rec.present = 1'b0;
        end else begin
          job.rec.val_a = 32'(sw);
          job.rec.val_b = sht;
          job.rec.val_c = 16'(v[5:0]) + 16'd60;
        end
      end else if (pos_c >= 7'h36 && pos_c <= 7'h7D) begin
        if (hidx_c == 5'd0) tm_d = 2'd0;
        if (hidx_c == 5'd3) begin
          tm_d = (is_desc && (v == 8'hFC || v == 8'hFF || v == 8'hFE)) ? 2'd1 : 2'd0;
        end
        if (hidx_c >= 5'd5 && tm_d == 2'd1) begin
          if (v == 8'h0A) begin
            tm_d = 2'd2;
          end else begin
            job.op = OP_SINGLE;
            job.rec.kind  = KIND_TEXT;
            job.rec.slot  = hidx_c - 5'd5;
            job.rec.part  = 3'(dnum);
            job.rec.val_a = (v == 8'd0) ? 32'h20 : 32'(v);
            job.rec.val_b = 16'(held_q[3]);
          end
        end
        if (hidx_c == 5'(HoldDepth - 1) && !is_desc) begin
          job.op = OP_DTD;
          dcnt_d = dcnt_c + 3'd1;
        end
      end
    end
    if (pos_c == 7'd127) begin
      job.op = OP_SINGLE;
      job.rec = '0;
      job.rec.kind    = KIND_STATUS;
      job.rec.val_a   = 32'(sum_n);
      job.rec.val_b   = 16'(hm_n);
      job.rec.val_c   = 16'(dcnt_c);
      job.rec.present = 1'b1;
    end

    if (pos_c == 7'd127) begin
      pos_d  = 7'd0;
      hidx_d = 5'd0;
      sum_d  = 8'd0;
      hm_d   = 1'b1;
      dcnt_d = 3'd0;
      ecnt_d = 5'd0;
      tm_d   = 2'd0;
    end else begin
      pos_d  = pos_c + 7'd1;
      hidx_d = (hidx_c == 5'(HoldDepth - 1)) ? 5'd0 : hidx_c + 5'd1;
      sum_d  = sum_n;
      hm_d   = hm_n;
    end
  end

  assign job_o  = job;
  assign push_o = accept && (job.op != OP_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hidx_q <= '0;
      sum_q  <= '0;
      hm_q   <= 1'b1;
      dcnt_q <= '0;
      ecnt_q <= '0;
      tm_q   <= '0;
    end else if (accept) begin
      pos_q  <= pos_d;
      hidx_q <= hidx_d;
      sum_q  <= sum_d;
      hm_q   <= hm_d;
      dcnt_q <= dcnt_d;
      ecnt_q <= ecnt_d;
      tm_q   <= tm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) held_q[hidx_c] <= v;
  end

endmodule

FILE: design/edid_fifo.sv
// ----------------------------------------------------------------------------
// EDID job queue
// Two-entry queue of decoded jobs between the front and the back.
// ----------------------------------------------------------------------------
module edid_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  edid_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output edid_pkg::job_t job_o
);
  import edid_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= job_i;
  end

endmodule

FILE: design/edid_back.sv
// ----------------------------------------------------------------------------
// EDID parser back end
// Expands each job into records in the output register, one record per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module edid_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  edid_pkg::job_t  job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output edid_pkg::rec_t  rec_o,
  output logic            last_o
);
  import edid_pkg::*;

  logic [2:0] cnt_q;
  logic [7:0] done_q, rem, bit_sel;
  logic [2:0] bit_idx;
  logic       out_valid_q, last_q;
  rec_t       rec_q, rec;
  logic       is_last, load;
  est_t       e;
  logic [7:0] f;
  logic [15:0] st;
  logic [4:0] sync;
  logic [17:0][7:0] h;

  assign h = job_i.dtd;
  assign f = h[17];

  always_comb begin
    rem     = job_i.est_mask & ~done_q;
    bit_idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (rem[i]) bit_idx = 3'(i);
    end
    bit_sel = 8'd1 << bit_idx;
    e = est_entry({job_i.est_grp, bit_idx});

    st = 16'({f[6:5], f[0]});
    if (st == 16'd1) st = 16'd0;
    if (f[4]) sync = {!f[0], f[3] ? !f[2] : 1'b0, !f[3] && f[2], !f[3], 1'b1};
    else      sync = {1'b0, !f[1], f[2], f[3], 1'b0};

    rec = job_i.rec;
    is_last = 1'b1;
    case (job_i.op)
      OP_EST: begin
        rec = '0;
        rec.kind    = KIND_EST;
        rec.slot    = job_i.est_base + 5'(cnt_q);
        rec.val_a   = 32'(e.w);
        rec.val_b   = e.h;
        rec.val_c   = e.hz;
        rec.present = 1'b1;
        is_last = ((rem & ~bit_sel) == 8'd0);
      end
      OP_DTD: begin
        rec = '0;
        rec.kind    = KIND_DETAILED;
        rec.slot    = 5'(job_i.dtd_slot);
        rec.part    = cnt_q;
        rec.present = 1'b1;
        is_last = (cnt_q == 3'(DtdParts - 1));
        case (cnt_q)
          3'd0: begin
            rec.val_a = 32'({h[1], h[0]} * 30'd10000);
            rec.val_b = {4'd0, h[4][7:4], h[2]};
            rec.val_c = {4'd0, h[4][3:0], h[3]};
          end
          3'd1: begin
            rec.val_a = 32'({h[7][7:4], h[5]});
            rec.val_b = {4'd0, h[7][3:0], h[6]};
          end
          3'd2: begin
            rec.val_a = 32'({h[11][7:6], h[8]});
            rec.val_b = {6'd0, h[11][5:4], h[9]};
          end
          3'd3: begin
            rec.val_a = 32'({h[11][3:2], h[10][7:4]});
            rec.val_b = {10'd0, h[11][1:0], h[10][3:0]};
          end
          3'd4: begin
            rec.val_a = 32'({h[14][7:4], h[12]});
            rec.val_b = {4'd0, h[14][3:0], h[13]};
          end
          3'd5: begin
            rec.val_a = 32'(h[15]);
            rec.val_b = 16'(h[16]);
          end
          default: begin
            rec.val_a = 32'(f[7]);
            rec.val_b = st;
            rec.val_c = 16'(sync);
          end
        endcase
      end
      default: ;
    endcase
  end

  assign load  = valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      done_q      <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        if (is_last) begin
          cnt_q  <= '0;
          done_q <= '0;
        end else begin
          cnt_q  <= cnt_q + 3'd1;
          done_q <= done_q | bit_sel;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rec_q  <= rec;
      last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rec_o       = rec_q;
  assign last_o      = last_q;

endmodule

FILE: design/edid_base_block_parser.sv
// ----------------------------------------------------------------------------
// EDID base block parser
// Decodes the 128 bytes of an EDID 1.3 base block into typed records.
// ----------------------------------------------------------------------------
// A record passes through the job queue and then the output register before
// it can be taken. Throughput: one byte per cycle while the two-entry job
// queue has room; the back end sends one record per cycle while the receiver
// is ready, so a byte that yields several records holds the back end until
// all are sent (up to seven for a detailed timing, eight for established
// timings). Reset clears all block state and empties the queue; the held byte
// store is not cleared and is always written before it is read.
module edid_base_block_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  record_kind_o,
  output logic [4:0]  slot_o,
  output logic [2:0]  part_o,
  output logic [31:0] value_a_o,
  output logic [15:0] value_b_o,
  output logic [15:0] value_c_o,
  output logic        present_o,
  output logic        last_of_run_o
);
  import edid_pkg::*;

  // The front end tracks byte position, checksum, header status and the
  // descriptor text state, and packs each byte into at most one job.
  logic push, full, q_valid, pop;
  job_t push_job, head_job;
  rec_t rec;

  edid_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_value_i (byte_value_i),
    .restart_i    (restart_i),
    .full_i       (full),
    .push_o       (push),
    .job_o        (push_job)
  );

  // The queue lets the front keep taking bytes while the back drains a
  // multi-record job.
  edid_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  // The back end walks each job record by record into the output register.
  edid_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rec_o       (rec),
    .last_o      (last_of_run_o)
  );

  assign record_kind_o = rec.kind;
  assign slot_o        = rec.slot;
  assign part_o        = rec.part;
  assign value_a_o     = rec.val_a;
  assign value_b_o     = rec.val_b;
  assign value_c_o     = rec.val_c;
  assign present_o     = rec.present;

endmodule

FILE: test/edid_base_block_parser_checker.sv
// ----------------------------------------------------------------------------
// EDID base block parser checker
// Watches both word channels of the parser, predicts the decoded records of
// every accepted byte and compares each accepted record with the oldest one.
// ----------------------------------------------------------------------------
module edid_base_block_parser_checker
  import edid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  byte_value_i,
  input  logic        restart_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  record_kind_i,
  input  logic [4:0]  slot_i,
  input  logic [2:0]  part_i,
  input  logic [31:0] value_a_i,
  input  logic [15:0] value_b_i,
  input  logic [15:0] value_c_i,
  input  logic        present_i,
  input  logic        last_of_run_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] TXT_NONE  = 2'd0;
  localparam logic [1:0] TXT_OPEN  = 2'd1;
  localparam logic [1:0] TXT_ENDED = 2'd2;

  typedef struct packed {
    logic [3:0]  kind;
    logic [4:0]  slot;
    logic [2:0]  part;
    logic [31:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic        present;
    logic        last;
  } edid_record_t;

  edid_record_t record_q[$];

  logic [6:0] pos;
  logic [7:0] sum;
  logic       hdr_ok;
  logic [7:0] held [18];
  logic [2:0] dtd_count;
  logic [4:0] est_count;
  logic [1:0] txt_state;

  int mismatches = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = record_q.size();

  function automatic void clear_block();
    pos       = '0;
    sum       = '0;
    hdr_ok    = 1'b1;
    dtd_count = '0;
    est_count = '0;
    txt_state = TXT_NONE;
  endfunction

  function automatic void put(logic [3:0] kind, int unsigned slot, int unsigned part,
                              int unsigned a, int unsigned b, int unsigned c, logic pres);
    edid_record_t r;
    r.kind    = kind;
    r.slot    = slot[4:0];
    r.part    = part[2:0];
    r.a       = a;
    r.b       = b[15:0];
    r.c       = c[15:0];
    r.present = pres;
    r.last    = 1'b0;
    record_q.push_back(r);
  endfunction

  // Established timing modes, three bytes of eight bits, bit 0 first.
  function automatic void est_mode(int unsigned idx, output int unsigned w,
                                   output int unsigned h, output int unsigned hz);
    w = 0; h = 0; hz = 0;
    case (idx)
      0:  begin w = 800;  h = 600;  hz = 60; end
      1:  begin w = 800;  h = 600;  hz = 56; end
      2:  begin w = 640;  h = 480;  hz = 75; end
      3:  begin w = 640;  h = 480;  hz = 72; end
      4:  begin w = 640;  h = 480;  hz = 67; end
      5:  begin w = 640;  h = 480;  hz = 60; end
      6:  begin w = 720;  h = 400;  hz = 88; end
      7:  begin w = 720;  h = 400;  hz = 70; end
      8:  begin w = 1280; h = 1024; hz = 75; end
      9:  begin w = 1024; h = 768;  hz = 75; end
      10: begin w = 1024; h = 768;  hz = 70; end
      11: begin w = 1024; h = 768;  hz = 60; end
      12: begin w = 1024; h = 768;  hz = 87; end
      13: begin w = 832;  h = 624;  hz = 75; end
      14: begin w = 800;  h = 600;  hz = 75; end
      15: begin w = 800;  h = 600;  hz = 72; end
      23: begin w = 1152; h = 870;  hz = 75; end
      default: ;
    endcase
  endfunction

  function automatic void put_timing();
    int unsigned s, f, st, sync, comp, serr, nv, nh;
    s = dtd_count;
    f = held[17];
    put(KIND_DETAILED, s, 0, ({held[1], held[0]}) * 10000,
        {held[4][7:4], held[2]}, {held[4][3:0], held[3]}, 1'b1);
    put(KIND_DETAILED, s, 1, {held[7][7:4], held[5]}, {held[7][3:0], held[6]}, 0, 1'b1);
    put(KIND_DETAILED, s, 2, {held[11][7:6], held[8]}, {held[11][5:4], held[9]}, 0, 1'b1);
    put(KIND_DETAILED, s, 3, {held[11][3:2], held[10][7:4]}, {held[11][1:0], held[10][3:0]},
        0, 1'b1);
    put(KIND_DETAILED, s, 4, {held[14][7:4], held[12]}, {held[14][3:0], held[13]}, 0, 1'b1);
    put(KIND_DETAILED, s, 5, held[15], held[16], 0, 1'b1);
    // Stereo code 1 means the same as 0.
    st = (((f >> 5) & 3) << 1) | (f & 1);
    if (st == 1) st = 0;
    if (f[4]) begin
      comp = f[3] ? 0 : 1;
      serr = comp ? f[2] : 0;
      nv   = comp ? 0 : (f[2] ? 0 : 1);
      nh   = f[0] ? 0 : 1;
      sync = 1 | (comp << 1) | (serr << 2) | (nv << 3) | (nh << 4);
    end else begin
      sync = (f[3] << 1) | (f[2] << 2) | ((f[1] ? 0 : 1) << 3);
    end
    put(KIND_DETAILED, s, 6, f[7], st, sync, 1'b1);
    dtd_count = dtd_count + 3'd1;
  endfunction

  function automatic void decode(int unsigned p, logic [7:0] v);
    int unsigned k, lo, sh, w, ht, d, off, l0, l1, l2;
    logic is_desc;
    logic [7:0] f;
    if (p == 'h0B) begin
      l0 = held[8][6:2];
      l1 = {held[8][1:0], held[9][7:5]};
      l2 = held[9][4:0];
      put(KIND_VENDOR, 0, 0, ((64 + l0) << 16) | ((64 + l1) << 8) | (64 + l2),
          {v, held[10]}, 0, 1'b1);
    end else if (p == 'h0F) begin
      put(KIND_SERIAL, 0, 0, {v, held[14], held[13], held[12]}, 0, 0, 1'b1);
    end else if (p == 'h11) begin
      // Week 0xFF flags a model year; week 0 means no week given.
      w = held[16];
      k = (w != 0 && w != 255) ? 1 : 0;
      put(KIND_DATE, 0, 0, k ? w : 0, 1990 + v, (w == 255 ? 1 : 0) | (k << 1), 1'b1);
    end else if (p == 'h13) begin
      put(KIND_VERSION, 0, 0, held[0], v, 0, 1'b1);
    end else if (p == 'h14) begin
      if (v[7]) begin
        case (v[6:4])
          3'd1: d = 6;
          3'd2: d = 8;
          3'd3: d = 10;
          3'd4: d = 12;
          3'd5: d = 14;
          3'd6: d = 16;
          default: d = 0;
        endcase
        put(KIND_INPUT, 0, 0, 1, d, v[3:0], 1'b1);
      end else begin
        put(KIND_INPUT, 0, 0, 0, v[6:5], v[4:0], 1'b1);
      end
    end else if (p == 'h16) begin
      w = held[3];
      if (w == 0 && v == 0) put(KIND_SIZE, 0, 0, 0, 0, 0, 1'b0);
      else if (v == 0) put(KIND_SIZE, 0, 0, 0, 0, w + 99, 1'b1);
      else if (w == 0) begin
        d = v + 99;
        put(KIND_SIZE, 0, 0, 0, 0, (10000 + d / 2) / d, 1'b1);
      end else put(KIND_SIZE, 0, 0, 10 * w, 10 * v, 0, 1'b1);
    end else if (p == 'h17) begin
      if (v == 8'hFF) put(KIND_GAMMA, 0, 0, 0, 0, 0, 1'b0);
      else put(KIND_GAMMA, 0, 0, v + 100, 0, 0, 1'b1);
    end else if (p == 'h18) begin
      put(KIND_FEATURES, 0, 0, v[7:5], v[4:3], v[2:0], 1'b1);
    end else if (p >= 'h1B && p <= 'h22) begin
      // The low bits of each code sit in byte 0x19 or 0x1A, in spec order.
      k  = p - 'h1B;
      lo = held[k < 4 ? 7 : 8];
      sh = 6 - 2 * (k & 3);
      put(KIND_CHROMA, k, 0, (v << 2) | ((lo >> sh) & 3), 0, 0, 1'b1);
    end else if (p >= 'h23 && p <= 'h25) begin
      for (int j = 0; j < 8; j++) begin
        est_mode((p - 'h23) * 8 + j, w, ht, d);
        if (v[j] && d != 0) begin
          put(KIND_EST, est_count, 0, w, ht, d, 1'b1);
          est_count = est_count + 5'd1;
        end
      end
    end else if (p >= 'h27 && p <= 'h35 && p[0]) begin
      k = (p - 'h27) / 2;
      f = held[(p - 1) % 18];
      if (f == 8'h01 || v == 8'h01) begin
        put(KIND_STD, k, 0, 0, 0, 0, 1'b0);
      end else begin
        w = 8 * (f + 31);
        case (v[7:6])
          2'd0: ht = (w / 16) * 10;
          2'd1: ht = (w / 4) * 3;
          2'd2: ht = (w / 5) * 4;
          default: ht = (w / 16) * 9;
        endcase
        put(KIND_STD, k, 0, w, ht, v[5:0] + 60, 1'b1);
      end
    end else if (p >= 'h36 && p <= 'h7D) begin
      off     = (p - 'h36) % 18;
      d       = (p - 'h36) / 18;
      is_desc = (held[0] == 8'h00 && held[1] == 8'h00);
      if (off == 0) txt_state = TXT_NONE;
      if (off == 3) begin
        txt_state = (is_desc && (v == 8'hFC || v == 8'hFF || v == 8'hFE)) ? TXT_OPEN
                                                                           : TXT_NONE;
      end
      if (off >= 5 && txt_state == TXT_OPEN) begin
        // A line feed closes the string and yields nothing itself.
        if (v == 8'h0A) txt_state = TXT_ENDED;
        else put(KIND_TEXT, off - 5, d, (v == 8'h00) ? 32 : v, held[3], 0, 1'b1);
      end
      if (off == 17 && !is_desc) put_timing();
    end
  endfunction

  function automatic void take_byte(logic [7:0] v, logic rs);
    int unsigned p, n0;
    if (rs) clear_block();
    p   = pos;
    sum = sum + v;
    if (p < 8) begin
      if (v != ((p == 0 || p == 7) ? 8'h00 : 8'hFF)) hdr_ok = 1'b0;
    end
    held[p % 18] = v;
    n0 = record_q.size();
    if (hdr_ok) decode(p, v);
    if (p == 127) begin
      put(KIND_STATUS, 0, 0, sum, hdr_ok, dtd_count, 1'b1);
      clear_block();
    end else begin
      pos = pos + 7'd1;
    end
    if (record_q.size() > n0) record_q[record_q.size() - 1].last = 1'b1;
  endfunction

  initial begin
    clear_block();
    foreach (held[i]) held[i] = '0;
  end

  always @(posedge clk_i) begin
    edid_record_t want, got;
    if (rst_ni) begin
      // Records are registered after their byte is taken, so taking the byte
      // first never lets a record overtake its own expectation.
      if (in_valid_i && in_ready_i) take_byte(byte_value_i, restart_i);
      if (out_valid_i && out_ready_i) begin
        got = '{record_kind_i, slot_i, part_i, value_a_i, value_b_i, value_c_i,
                present_i, last_of_run_i};
        if (record_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected record %p", got);
        end else begin
          want = record_q.pop_front();
          if (want != got) begin
            mismatches++;
            if (mismatches <= 10) $display("record mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  final begin
    // Left-over expectations are judged by the top through pending_o.
  end

endmodule

FILE: test/edid_base_block_parser_tb.sv
// ----------------------------------------------------------------------------
// EDID base block parser testbench
// Feeds directed and random EDID blocks through the parser under varying
// idling and back pressure; the checker predicts and compares every record.
// ----------------------------------------------------------------------------
module edid_base_block_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int RandomWords = 210;
  localparam int HoldCycles = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  byte_value_i = '0;
  logic        restart_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  record_kind_o;
  logic [4:0]  slot_o;
  logic [2:0]  part_o;
  logic [31:0] value_a_o;
  logic [15:0] value_b_o;
  logic [15:0] value_c_o;
  logic        present_o;
  logic        last_of_run_o;

  int fail_count;
  int pending;

  // Idling percentages, set by the stimulus and read by the receiver.
  int send_idle = 0;
  int recv_stall = 0;
  // Raised once by the stimulus; the receiver times its own hold-off.
  logic hold_req = 1'b0;

  edid_base_block_parser dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .byte_value_i, .restart_i,
    .out_valid_o, .out_ready_i, .record_kind_o, .slot_o, .part_o,
    .value_a_o, .value_b_o, .value_c_o, .present_o, .last_of_run_o
  );

  edid_base_block_parser_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .byte_value_i, .restart_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .record_kind_i(record_kind_o), .slot_i(slot_o), .part_i(part_o),
    .value_a_i(value_a_o), .value_b_i(value_b_o), .value_c_i(value_c_o),
    .present_i(present_o), .last_of_run_i(last_of_run_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus one long hold-off so the job queue fills
  // up and the parser has to drop in_ready_o.
  always @(posedge clk_i) begin
    int hold_left;
    int hold_done;
    if (hold_req && hold_done == 0) begin
      hold_done = 1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("FAIL edid_base_block_parser");
    $finish;
  end

  // Offer one word and hold it until the parser takes it.
  task automatic send_word(logic [7:0] value, logic rs);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_value_i <= value;
    restart_i    <= rs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Idling phases rotate every fifty random words.
  task automatic set_phase(int count);
    case ((count / 50) % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 45; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 45; end
      default: begin send_idle = 26; recv_stall = 26; end
    endcase
  endtask

  // Build a plausible base block with random content. Special values are
  // favored: zero sizes, gamma 0xFF, unused standard timings, text
  // descriptors with line feeds and NULs, and unsupported tags.
  task automatic build_block(output logic [7:0] blk [128]);
    int kind, stop, b;
    foreach (blk[i]) blk[i] = 8'($urandom);
    for (int i = 0; i < 8; i++) blk[i] = (i == 0 || i == 7) ? 8'h00 : 8'hFF;
    blk['h12] = 8'h01;
    if ($urandom_range(3) == 0) blk['h15] = 8'h00;
    if ($urandom_range(3) == 0) blk['h16] = 8'h00;
    if ($urandom_range(4) == 0) blk['h17] = 8'hFF;
    if ($urandom_range(3) == 0) blk['h10] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
    for (int i = 'h26; i <= 'h35; i++) begin
      if ($urandom_range(4) == 0) blk[i] = 8'h01;
    end
    for (int dsc = 0; dsc < 4; dsc++) begin
      b = 'h36 + 18 * dsc;
      kind = $urandom_range(2);
      if (kind == 0) begin
        if (blk[b] == 8'h00 && blk[b + 1] == 8'h00) blk[b] = 8'h01;
      end else begin
        blk[b] = 8'h00;
        blk[b + 1] = 8'h00;
        blk[b + 2] = 8'h00;
        if (kind == 1) begin
          case ($urandom_range(2))
            0: blk[b + 3] = 8'hFC;
            1: blk[b + 3] = 8'hFF;
            default: blk[b + 3] = 8'hFE;
          endcase
          stop = $urandom_range(5, 18);
          for (int i = 5; i < 18; i++) begin
            if (i < stop) blk[b + i] = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(32, 255));
            else if (i == stop) blk[b + i] = 8'h0A;
            else blk[b + i] = ($urandom_range(1) != 0) ? 8'h20 : 8'($urandom);
          end
        end
      end
    end
  endtask

  initial begin
    logic [7:0] blk [128];
    int sent, sel, len;
    logic need_restart;
    logic [7:0] directed [21];

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a broken header first, then a restart into a block whose
    // ID, serial, date and version bytes sit at their extremes.
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    directed = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'hFF, 8'hFF, 8'h01, 8'h04, 8'hFF};
    foreach (directed[i]) send_word(directed[i], i == 0);

    // Random: mostly whole blocks, with broken headers, cut-off blocks and
    // noise mixed in. The first block runs against the long hold-off.
    sent = 0;
    need_restart = 1'b1;
    hold_req <= 1'b1;
    while (sent < RandomWords) begin
      sel = (sent == 0) ? 0 : $urandom_range(9);
      build_block(blk);
      len = 128;
      if (sel == 7) blk[$urandom_range(7)] = 8'($urandom);
      if (sel == 8) len = $urandom_range(1, 127);
      if (sel == 9) begin
        len = $urandom_range(1, 10);
        foreach (blk[i]) blk[i] = 8'($urandom);
      end
      for (int i = 0; i < len; i++) begin
        if (sent > 0) set_phase(sent);
        send_word(blk[i], (i == 0) ? (need_restart | ($urandom_range(1) != 0))
                                   : (sel == 9 && $urandom_range(3) == 0));
        sent++;
      end
      need_restart = (len != 128);
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS edid_base_block_parser");
    end else begin
      $display("FAIL edid_base_block_parser");
    end
    $finish;
  end

endmodule
